// File: sv/indexed_sequence_list_core_macros.svh
// ----------------------------------------------------------------------------
// indexed_sequence_list_core_macros.svh
// Assertion helpers shared by the sequence list core.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SEQUENCE_LIST_CORE_MACROS_SVH
`define INDEXED_SEQUENCE_LIST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ISL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isl assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ISL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isl assertion failed");

`endif

// File: sv/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// Shared widths, codes and defaults of the sequence list core.
// ----------------------------------------------------------------------------
package isl_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 6;
	localparam int LEN_W        = 7;
	localparam int DEF_CAPACITY = 64;

	typedef enum logic [1:0] {
		FUNC_INSERT  = 2'd0,
		FUNC_ERASE   = 2'd1,
		FUNC_REVERSE = 2'd2,
		FUNC_DUMP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

// File: sv/indexed_sequence_list_core.sv
// Insert, erase and reverse take longer the more entries they must move; a refused op
//   or an empty dump goes straight to ST_DONE.
// Dump: each element is read (ST_DUMP_RD), then output (ST_DUMP_OUT).
// Flow: one item at a time; in_ready only in idle, so the next transfer can be accepted in
//   the cycle after the last result loads; a result held waiting for out_ready delays it.
// Reset: arst_n clears the sequencer, count and output valid; memory is not cleared.
// ----------------------------------------------------------------------------
// indexed_sequence_list_core
// Ordered list of signed 32-bit values with insert, erase, reverse and dump.
// ----------------------------------------------------------------------------
`include "indexed_sequence_list_core_macros.svh"

module indexed_sequence_list_core #(
	parameter int CAPACITY = isl_pkg::DEF_CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// request channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic [isl_pkg::POS_W-1:0]         position,
	input  logic signed [isl_pkg::DATA_W-1:0] value,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic signed [isl_pkg::DATA_W-1:0] element,
	output logic                              element_valid,
	output logic [isl_pkg::POS_W-1:0]         element_index,
	output logic [isl_pkg::LEN_W-1:0]         list_length,
	output logic                              last
);

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = isl_pkg::LEN_W;
	localparam logic [LW-1:0] CAP_CNT = LW'(CAPACITY);
	localparam logic [LW-1:0] ONE     = LW'(1);
	localparam logic [LW-1:0] THREE   = LW'(3);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_INS_PUT,
		ST_ERA_RD,
		ST_ERA_WR,
		ST_REV_RDA,
		ST_REV_RDB,
		ST_REV_WRA,
		ST_REV_WRB,
		ST_DUMP_RD,
		ST_DUMP_OUT,
		ST_DONE
	} state_t;

	state_t                      state_q;
	logic [LW-1:0]               cnt_q;     // entries in the list
	logic [LW-1:0]               cur_q;     // working index (insert/erase/dump, reverse low)
	logic [LW-1:0]               hi_q;      // reverse: one past the high index
	logic [LW-1:0]               pos_q;
	logic [isl_pkg::DATA_W-1:0]  val_q;
	logic [isl_pkg::DATA_W-1:0]  tmp_q;     // reverse: low entry in flight
	isl_pkg::status_t            res_q;     // status of a single-result op

	// output register
	logic                        out_valid_q;
	logic [1:0]                  status_q;
	logic [isl_pkg::DATA_W-1:0]  element_q;
	logic                        element_valid_q;
	logic [isl_pkg::POS_W-1:0]   element_index_q;
	logic [LW-1:0]               list_length_q;
	logic                        last_q;

	// memory port
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [isl_pkg::DATA_W-1:0]  mem_wdata;
	logic                        mem_re;
	logic [AW-1:0]               mem_raddr;
	logic [isl_pkg::DATA_W-1:0]  mem_rdata;

	logic [LW-1:0]               in_pos;
	logic [LW-1:0]               cur_dec;
	logic [LW-1:0]               cur_inc;
	logic [LW-1:0]               hi_dec;
	logic                        out_free;
	logic                        out_load;  // a result enters the output register

	assign in_pos   = LW'(position);
	assign cur_dec  = cur_q - ONE;
	assign cur_inc  = cur_q + ONE;
	assign hi_dec   = hi_q - ONE;
	assign out_free = !out_valid_q || out_ready;
	assign out_load = out_free && ((state_q == ST_DONE) || (state_q == ST_DUMP_OUT));
	assign in_ready = (state_q == ST_IDLE);

	// Memory port steering: one read or one write per step.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = cur_q[AW-1:0];
		unique case (state_q)
			ST_INS_RD: begin
				mem_re    = 1'b1;
				mem_raddr = cur_dec[AW-1:0];
			end
			ST_INS_WR: begin
				mem_we = 1'b1;
			end
			ST_INS_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = val_q;
			end
			ST_ERA_RD: begin
				mem_re    = 1'b1;
				mem_raddr = cur_inc[AW-1:0];
			end
			ST_ERA_WR: begin
				mem_we = 1'b1;
			end
			ST_REV_RDA: begin
				mem_re = 1'b1;
			end
			ST_REV_RDB: begin
				mem_re    = 1'b1;
				mem_raddr = hi_dec[AW-1:0];
			end
			ST_REV_WRA: begin
				mem_we = 1'b1;
			end
			ST_REV_WRB: begin
				mem_we    = 1'b1;
				mem_waddr = hi_dec[AW-1:0];
				mem_wdata = tmp_q;
			end
			ST_DUMP_RD: begin
				mem_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	isl_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						pos_q <= in_pos;
						val_q <= value;
						res_q <= isl_pkg::ST_OK;
						unique case (isl_pkg::func_t'(func))
							isl_pkg::FUNC_INSERT: begin
								cur_q <= cnt_q;
								if (in_pos > cnt_q) begin
									res_q   <= isl_pkg::ST_RANGE;
									state_q <= ST_DONE;
								end else if (cnt_q >= CAP_CNT) begin
									res_q   <= isl_pkg::ST_FULL;
									state_q <= ST_DONE;
								end else begin
									cnt_q   <= cnt_q + ONE;
									state_q <= (in_pos == cnt_q) ? ST_INS_PUT : ST_INS_RD;
								end
							end
							isl_pkg::FUNC_ERASE: begin
								cur_q <= in_pos;
								if (in_pos >= cnt_q) begin
									res_q   <= isl_pkg::ST_RANGE;
									state_q <= ST_DONE;
								end else begin
									cnt_q   <= cnt_q - ONE;
									state_q <= (in_pos + ONE < cnt_q) ? ST_ERA_RD : ST_DONE;
								end
							end
							isl_pkg::FUNC_REVERSE: begin
								cur_q   <= '0;
								hi_q    <= cnt_q;
								state_q <= (cnt_q > ONE) ? ST_REV_RDA : ST_DONE;
							end
							isl_pkg::FUNC_DUMP: begin
								cur_q   <= '0;
								state_q <= (cnt_q == '0) ? ST_DONE : ST_DUMP_RD;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				// insert: shift entries up one slot, top down
				ST_INS_RD: begin
					state_q <= ST_INS_WR;
				end
				ST_INS_WR: begin
					cur_q   <= cur_dec;
					state_q <= (cur_dec == pos_q) ? ST_INS_PUT : ST_INS_RD;
				end
				ST_INS_PUT: begin
					state_q <= ST_DONE;
				end
				// erase: shift entries down one slot; cnt_q already holds the new length
				ST_ERA_RD: begin
					state_q <= ST_ERA_WR;
				end
				ST_ERA_WR: begin
					cur_q   <= cur_inc;
					state_q <= (cur_inc < cnt_q) ? ST_ERA_RD : ST_DONE;
				end
				// reverse: swap the outer pair, move inward
				ST_REV_RDA: begin
					state_q <= ST_REV_RDB;
				end
				ST_REV_RDB: begin
					tmp_q   <= mem_rdata;
					state_q <= ST_REV_WRA;
				end
				ST_REV_WRA: begin
					state_q <= ST_REV_WRB;
				end
				ST_REV_WRB: begin
					cur_q   <= cur_inc;
					hi_q    <= hi_dec;
					state_q <= (cur_q + THREE < hi_q) ? ST_REV_RDA : ST_DONE;
				end
				// dump: one element per read, held until the output slot frees
				ST_DUMP_RD: begin
					state_q <= ST_DUMP_OUT;
				end
				ST_DUMP_OUT: begin
					if (out_free) begin
						status_q        <= isl_pkg::ST_OK;
						element_q       <= mem_rdata;
						element_valid_q <= 1'b1;
						element_index_q <= cur_q[isl_pkg::POS_W-1:0];
						list_length_q   <= cnt_q;
						last_q          <= (cur_inc == cnt_q);
						cur_q           <= cur_inc;
						state_q         <= (cur_inc == cnt_q) ? ST_IDLE : ST_DUMP_RD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						status_q        <= res_q;
						element_q       <= '0;
						element_valid_q <= 1'b0;
						element_index_q <= '0;
						list_length_q   <= cnt_q;
						last_q          <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign element       = element_q;
	assign element_valid = element_valid_q;
	assign element_index = element_index_q;
	assign list_length   = list_length_q;
	assign last          = last_q;

	// Checks
	`ISL_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_q <= CAP_CNT)
	`ISL_ASSERT_IMP(a_full_len, out_valid && status == isl_pkg::ST_FULL, list_length == CAP_CNT)
	`ISL_ASSERT_IMP(a_dump_last, out_valid && element_valid && last, LW'(element_index) + ONE == list_length)
	`ISL_ASSERT_IMP(a_we_busy, mem_we, state_q != ST_IDLE)
	`ISL_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready)

endmodule

// File: sv/isl_store.sv
// ----------------------------------------------------------------------------
// isl_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module isl_store #(
	parameter int DEPTH = isl_pkg::DEF_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [isl_pkg::DATA_W-1:0] wdata,
	input  logic                      re,
	input  logic [AW-1:0]             raddr,
	output logic [isl_pkg::DATA_W-1:0] rdata
);

	logic [isl_pkg::DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
